// File: sv/svr_pkg.sv
// Shared constants, types and helper functions of the sphere voxel rasterizer.
package svr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIM_X_LOG2 = 6;
  localparam int DIM_Y_LOG2 = 6;
  localparam int DIM_Z_LOG2 = 6;
  localparam int DIM_X      = 1 << DIM_X_LOG2;
  localparam int DIM_Y      = 1 << DIM_Y_LOG2;
  localparam int DIM_Z      = 1 << DIM_Z_LOG2;

  localparam int IN_W  = 16;
  localparam int VOX_W = 6;

  localparam int CRD_XY = (DIM_X_LOG2 > DIM_Y_LOG2) ? DIM_X_LOG2 : DIM_Y_LOG2;
  localparam int CRD_W  = (CRD_XY > DIM_Z_LOG2) ? CRD_XY : DIM_Z_LOG2;
  localparam int EXT_W  = CRD_W + VOX_W;

  localparam int SUM_W  = ((IN_W > FRAC_BITS) ? IN_W : FRAC_BITS) + 2;
  localparam int SQ_W   = 2 * SUM_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int PROD_W = SUM_W + CRD_W;

  localparam int ROW_AW = DIM_Y_LOG2 + DIM_Z_LOG2;
  localparam int ROWS   = DIM_Y * DIM_Z;

  localparam logic [SUM_W-1:0] R_MAX = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

  localparam logic [CRD_W-1:0] DX_M1 = CRD_W'(DIM_X - 1);
  localparam logic [CRD_W-1:0] DY_M1 = CRD_W'(DIM_Y - 1);
  localparam logic [CRD_W-1:0] DZ_M1 = CRD_W'(DIM_Z - 1);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SQ_R = 2'd0,
    SQ_Z = 2'd1,
    SQ_Y = 2'd2
  } sq_sel_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_BND,
    ST_R_SQ,
    ST_R_SAVE,
    ST_Z_SQ,
    ST_Z_SAVE,
    ST_Y_SQ,
    ST_Y_SAVE,
    ST_X_WALK,
    ST_X_DRAIN,
    ST_ROW_WR,
    ST_RD_ISSUE,
    ST_RD_CAP
  } state_t;

  typedef struct packed {
    logic    load;
    logic    bnd_en;
    logic    sq_en;
    sq_sel_t sq_sel;
    logic    r2_save;
    logic    z_init;
    logic    z_inc;
    logic    sz_save;
    logic    y_init;
    logic    y_inc;
    logic    syz_save;
    logic    walk;
    logic    row_wr;
    logic    clr_wr;
    logic    rd_issue;
    logic    rd_cap;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bnd_last;
    logic       x_last;
    logic       y_last;
    logic       z_last;
    logic       clr_last;
  } sts_t;

  // Normalized position floor(v * 2^FRAC_BITS / 2^log2d); always below 2^FRAC_BITS.
  function automatic logic signed [SUM_W-1:0] norm_pos(input logic [CRD_W-1:0] v,
                                                      input int log2d);
    logic [CRD_W+FRAC_BITS-1:0] t;
    t = {v, {FRAC_BITS{1'b0}}};
    return $signed(SUM_W'(t >> log2d));
  endfunction

endpackage

// File: sv/sphere_voxel_rasterizer_core.sv
// Top level of the sphere voxel rasterizer: controller, datapath and voxel row store.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_ready  | mode, center_x/y/z, radius, voxel_x/y/z
//  out     | out_valid / out_ready| occupied, mode_done
//
// Clear writes one store row a cycle; in add sphere the walk marks one voxel a cycle
// and each row is a read-modify-write of one store word.
// Reset starts a clearing pass over all DIM_Y*DIM_Z rows (4096) with in_ready low.
// One transaction is worked at a time; a finished result waits in the output register
// and the block stalls before loading the next result until it is taken.
module sphere_voxel_rasterizer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [svr_pkg::IN_W-1:0]  center_x,
  input  logic [svr_pkg::IN_W-1:0]  center_y,
  input  logic [svr_pkg::IN_W-1:0]  center_z,
  input  logic [svr_pkg::IN_W-1:0]  radius,
  input  logic [svr_pkg::VOX_W-1:0] voxel_x,
  input  logic [svr_pkg::VOX_W-1:0] voxel_y,
  input  logic [svr_pkg::VOX_W-1:0] voxel_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      occupied,
  output logic [1:0]                mode_done
);
  import svr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .mode     (mode),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .radius   (radius),
    .voxel_x  (voxel_x),
    .voxel_y  (voxel_y),
    .voxel_z  (voxel_z),
    .occupied (occupied),
    .mode_done(mode_done)
  );

endmodule

// File: sv/svr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/svr_dp.sv
// Datapath: operand registers, bound and square units, voxel walk pipeline, row store.
module svr_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  svr_pkg::cmd_t            cmd,
  output svr_pkg::sts_t            sts,
  input  logic [1:0]               mode,
  input  logic [svr_pkg::IN_W-1:0] center_x,
  input  logic [svr_pkg::IN_W-1:0] center_y,
  input  logic [svr_pkg::IN_W-1:0] center_z,
  input  logic [svr_pkg::IN_W-1:0] radius,
  input  logic [svr_pkg::VOX_W-1:0] voxel_x,
  input  logic [svr_pkg::VOX_W-1:0] voxel_y,
  input  logic [svr_pkg::VOX_W-1:0] voxel_z,
  output logic                     occupied,
  output logic [1:0]               mode_done
);
  import svr_pkg::*;

  localparam logic [2:0] BND_X_LO = 3'd0;
  localparam logic [2:0] BND_X_HI = 3'd1;
  localparam logic [2:0] BND_Y_LO = 3'd2;
  localparam logic [2:0] BND_Y_HI = 3'd3;
  localparam logic [2:0] BND_Z_LO = 3'd4;
  localparam logic [2:0] BND_Z_HI = 3'd5;

  logic [1:0]       mode_r;
  logic [IN_W-1:0]  cx, cy, cz;
  logic [SUM_W-1:0] rs;
  logic [VOX_W-1:0] vx, vy, vz;
  logic             in_rng;
  logic [2:0]       step;
  logic [CRD_W-1:0] x0, x1, y0, y1, z0, z1;
  logic [CRD_W-1:0] x, y, z;
  logic [SQ_W-1:0]  sq, r2, sz;
  logic [DIST_W-1:0] syz;
  logic [SQ_W-1:0]  dx2;
  logic [DIM_X_LOG2-1:0] xs1;
  logic             v1;
  logic [DIM_X-1:0] row;
  logic [ROW_AW-1:0] clr_cnt;

  logic signed [SUM_W-1:0] cxs, cys, czs, rss;
  logic signed [SUM_W-1:0] b_c, b_v, b_pos;
  logic [CRD_W-1:0]        b_dm1;
  logic [PROD_W-1:0]       b_prod, b_q;
  logic [CRD_W-1:0]        b_res;
  logic signed [SUM_W-1:0] sq_d, dx;
  logic signed [SQ_W-1:0]  sq_p, dx_p;
  logic [DIST_W-1:0]       dsq;
  logic                    hit;
  logic [EXT_W-1:0]        vx_e, vy_e, vz_e;
  logic [ROW_AW-1:0]       row_addr, rd_addr;
  logic                    ram_we;
  logic [ROW_AW-1:0]       ram_waddr, ram_raddr;
  logic [DIM_X-1:0]        ram_wdata, ram_rdata;

  assign cxs = $signed(SUM_W'(cx));
  assign cys = $signed(SUM_W'(cy));
  assign czs = $signed(SUM_W'(cz));
  assign rss = $signed(rs);

  // Bound unit: one axis end per step, floor((dim-1) * (c +/- r)), clamped.
  always_comb begin
    case (step[2:1])
      2'd0: begin
        b_c   = cxs;
        b_dm1 = DX_M1;
      end
      2'd1: begin
        b_c   = cys;
        b_dm1 = DY_M1;
      end
      default: begin
        b_c   = czs;
        b_dm1 = DZ_M1;
      end
    endcase
    b_v    = step[0] ? (b_c + rss) : (b_c - rss);
    b_pos  = b_v[SUM_W-1] ? '0 : b_v;
    b_prod = PROD_W'($unsigned(b_pos)) * PROD_W'(b_dm1);
    b_q    = b_prod >> FRAC_BITS;
    b_res  = (b_q > PROD_W'(b_dm1)) ? b_dm1 : CRD_W'(b_q);
  end

  // Shared square unit for r, dz and dy.
  always_comb begin
    case (cmd.sq_sel)
      SQ_R:    sq_d = rss;
      SQ_Z:    sq_d = norm_pos(z, DIM_Z_LOG2) - czs;
      SQ_Y:    sq_d = norm_pos(y, DIM_Y_LOG2) - cys;
      default: sq_d = '0;
    endcase
  end
  assign sq_p = sq_d * sq_d;

  // Walk pipeline: square dx, then add and compare against r*r.
  assign dx   = norm_pos(x, DIM_X_LOG2) - cxs;
  assign dx_p = dx * dx;
  assign dsq  = syz + DIST_W'(dx2);
  assign hit  = v1 && (dsq < DIST_W'(r2));

  assign vx_e = EXT_W'(vx);
  assign vy_e = EXT_W'(vy);
  assign vz_e = EXT_W'(vz);
  assign row_addr = {z[DIM_Z_LOG2-1:0], y[DIM_Y_LOG2-1:0]};
  assign rd_addr  = {vz_e[DIM_Z_LOG2-1:0], vy_e[DIM_Y_LOG2-1:0]};

  assign ram_we    = cmd.clr_wr || cmd.row_wr;
  assign ram_waddr = cmd.clr_wr ? clr_cnt : row_addr;
  assign ram_wdata = cmd.clr_wr ? '0 : row;
  // Hold the read address while the read result waits so the word stays put.
  assign ram_raddr = (cmd.rd_issue || cmd.rd_cap) ? rd_addr : row_addr;

  svr_ram #(
    .WIDTH(DIM_X),
    .DEPTH(ROWS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      v1      <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      v1 <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      cx     <= center_x;
      cy     <= center_y;
      cz     <= center_z;
      rs     <= (SUM_W'(radius) > R_MAX) ? R_MAX : SUM_W'(radius);
      vx     <= voxel_x;
      vy     <= voxel_y;
      vz     <= voxel_z;
      in_rng <= (EXT_W'(voxel_x) < EXT_W'(DIM_X)) && (EXT_W'(voxel_y) < EXT_W'(DIM_Y))
                && (EXT_W'(voxel_z) < EXT_W'(DIM_Z));
      step   <= '0;
    end
    if (cmd.bnd_en) begin
      step <= step + 1'b1;
      case (step)
        BND_X_LO: x0 <= b_res;
        BND_X_HI: x1 <= b_res;
        BND_Y_LO: y0 <= b_res;
        BND_Y_HI: y1 <= b_res;
        BND_Z_LO: z0 <= b_res;
        BND_Z_HI: z1 <= b_res;
        default: ;
      endcase
    end
    if (cmd.sq_en) begin
      sq <= $unsigned(sq_p);
    end
    if (cmd.r2_save) begin
      r2 <= sq;
    end
    if (cmd.z_init) begin
      z <= z0;
    end else if (cmd.z_inc) begin
      z <= z + 1'b1;
    end
    if (cmd.sz_save) begin
      sz <= sq;
    end
    if (cmd.y_init) begin
      y <= y0;
    end else if (cmd.y_inc) begin
      y <= y + 1'b1;
    end
    if (cmd.syz_save) begin
      syz <= DIST_W'(sz) + DIST_W'(sq);
      row <= ram_rdata;
      x   <= x0;
    end else begin
      if (cmd.walk) begin
        x <= x + 1'b1;
      end
      if (hit) begin
        row[xs1] <= 1'b1;
      end
    end
    dx2 <= $unsigned(dx_p);
    xs1 <= x[DIM_X_LOG2-1:0];
    if (cmd.res_load) begin
      occupied  <= (mode_r == MODE_READ) && in_rng && ram_rdata[vx_e[DIM_X_LOG2-1:0]];
      mode_done <= mode_r;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.bnd_last = (step == BND_Z_HI);
  assign sts.x_last   = (x == x1);
  assign sts.y_last   = (y == y1);
  assign sts.z_last   = (z == z1);
  assign sts.clr_last = &clr_cnt;

endmodule

// File: sv/svr_ctrl.sv
// Controller: sequences clear, sphere walk and read transactions and owns the result valid.
module svr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  svr_pkg::sts_t sts,
  output svr_pkg::cmd_t cmd
);
  import svr_pkg::*;

  state_t state, state_next;
  logic   finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign finish = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sq_sel = SQ_R;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.mode)
          MODE_CLEAR: state_next = ST_CLEAR;
          MODE_ADD:   state_next = ST_BND;
          MODE_READ:  state_next = ST_RD_ISSUE;
          default: begin
            // unused mode: report without further work, touch nothing
            if (finish) begin
              cmd.res_load = 1'b1;
              state_next   = ST_IDLE;
            end
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_RD_CAP;
        end
      end
      ST_BND: begin
        cmd.bnd_en = 1'b1;
        if (sts.bnd_last) begin
          state_next = ST_R_SQ;
        end
      end
      ST_R_SQ: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_R;
        state_next = ST_R_SAVE;
      end
      ST_R_SAVE: begin
        cmd.r2_save = 1'b1;
        cmd.z_init  = 1'b1;
        state_next  = ST_Z_SQ;
      end
      ST_Z_SQ: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_Z;
        state_next = ST_Z_SAVE;
      end
      ST_Z_SAVE: begin
        cmd.sz_save = 1'b1;
        cmd.y_init  = 1'b1;
        state_next  = ST_Y_SQ;
      end
      ST_Y_SQ: begin
        // row read is issued here; data lands for the save state
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_Y;
        state_next = ST_Y_SAVE;
      end
      ST_Y_SAVE: begin
        cmd.syz_save = 1'b1;
        state_next   = ST_X_WALK;
      end
      ST_X_WALK: begin
        cmd.walk = 1'b1;
        if (sts.x_last) begin
          state_next = ST_X_DRAIN;
        end
      end
      ST_X_DRAIN: begin
        state_next = ST_ROW_WR;
      end
      ST_ROW_WR: begin
        cmd.row_wr = 1'b1;
        if (!sts.y_last) begin
          cmd.y_inc  = 1'b1;
          state_next = ST_Y_SQ;
        end else if (!sts.z_last) begin
          cmd.z_inc  = 1'b1;
          state_next = ST_Z_SQ;
        end else begin
          state_next = ST_RD_CAP;
        end
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        // read mode holds the store address; all modes that land here wait for the output slot
        cmd.rd_cap = (sts.mode == MODE_READ);
        if (finish) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/svr_checker.sv
// Port-level checker for the sphere voxel rasterizer, bound to the top level.
module svr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                mode,
  input logic [svr_pkg::IN_W-1:0]  center_x,
  input logic [svr_pkg::IN_W-1:0]  center_y,
  input logic [svr_pkg::IN_W-1:0]  center_z,
  input logic [svr_pkg::IN_W-1:0]  radius,
  input logic [svr_pkg::VOX_W-1:0] voxel_x,
  input logic [svr_pkg::VOX_W-1:0] voxel_y,
  input logic [svr_pkg::VOX_W-1:0] voxel_z,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      occupied,
  input logic [1:0]                mode_done
);
  import svr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode_done) && $stable(occupied))
    else $error("result changed while stalled");

  a_occ_read_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_done != MODE_READ) |-> !occupied)
    else $error("occupied set on a non-read result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while one is in work");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready && !out_valid)
    else $error("ready before the store clearing pass");

endmodule

bind sphere_voxel_rasterizer_core svr_checker u_svr_checker (.*);
